FILE: hdl/sgs_pkg.sv
package sgs_pkg;

   localparam int MAX_TAPS    = 32;
   localparam int IDX_BITS    = 5;
   localparam int EXT_LIMIT   = MAX_TAPS / 2;
   localparam int MAX_RESULTS = EXT_LIMIT + 1;
   localparam int NUM_BITS    = 5;
   localparam int SMP_BITS    = 16;
   localparam int COEF_BITS   = 18;
   localparam int FRAC_BITS   = 16;
   localparam int EXT_BITS    = 5;
   localparam int CNT_BITS    = 32;
   localparam int ACC_BITS    = 40;

   localparam logic MODE_TAP    = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   localparam logic REG_LEFT  = 1'b0;
   localparam logic REG_RIGHT = 1'b1;

   typedef struct packed {
      logic                        err;
      logic                        at_end;
      logic [CNT_BITS-1:0]         first;
      logic [CNT_BITS-1:0]         count;
      logic [NUM_BITS-1:0]         num;
   } job_type;

   typedef struct packed {
      logic                        tap_we;
      logic [IDX_BITS-1:0]         tap_addr;
      logic signed [COEF_BITS-1:0] tap_data;
      logic                        ring_we;
      logic                        head_we;
      logic [IDX_BITS-1:0]         smp_addr;
      logic signed [SMP_BITS-1:0]  smp_data;
   } wr_type;

   typedef struct packed {
      logic [EXT_BITS-1:0] left;
      logic [EXT_BITS-1:0] right;
   } ext_type;

   typedef struct packed {
      logic idle;
      logic pop;
   } back_sts_type;

endpackage

FILE: hdl/sgs_if.sv
interface sgs_req_if;
   import sgs_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [IDX_BITS-1:0]         tap_index;
   logic signed [COEF_BITS-1:0] coefficient;
   logic signed [SMP_BITS-1:0]  sample;
   logic                        last;
   modport source (output valid, mode, tap_index, coefficient, sample, last, input ready);
   modport sink (input valid, mode, tap_index, coefficient, sample, last, output ready);
endinterface

interface sgs_rsp_if;
   import sgs_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SMP_BITS-1:0] smoothed;
   logic                       last_result;
   logic                       error;
   modport source (output valid, smoothed, last_result, error, input ready);
   modport sink (input valid, smoothed, last_result, error, output ready);
endinterface

interface sgs_csr_if;
   import sgs_pkg::*;
   logic                valid;
   logic                ready;
   logic                index;
   logic [EXT_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/savitzky_golay_smoother_top.sv
// Savitzky-Golay smoother: one sample or tap item accepted at a time.
// Each output runs left+right+1 taps through the shared multiply-accumulate, then
// drains the read and multiply registers, rounds and saturates; a sample item
// yields 0 to 17 outputs. A tap item is written straight into the tap store.
// Synchronous active-high reset clears sample counters, state and handshake state,
// and sets both extents to 2; tap and sample stores keep their contents.
module savitzky_golay_smoother_top
   import sgs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   sgs_req_if.sink   req_bus,
   sgs_csr_if.sink   csr_bus,
   sgs_rsp_if.source rsp_bus
);

   wr_type       wr;
   ext_type      ext;
   logic         job_vld;
   job_type      job;
   back_sts_type back_sts;

   sgs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .csr_bus  (csr_bus),
      .back_sts (back_sts),
      .wr       (wr),
      .ext      (ext),
      .job_vld  (job_vld),
      .job      (job)
   );

   sgs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .ext      (ext),
      .job_vld  (job_vld),
      .job      (job),
      .back_sts (back_sts),
      .rsp_bus  (rsp_bus)
   );

endmodule

FILE: hdl/sgs_front.sv
module sgs_front
   import sgs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   sgs_req_if.sink        req_bus,
   sgs_csr_if.sink        csr_bus,
   input  back_sts_type   back_sts,
   output wr_type         wr,
   output ext_type        ext,
   output logic           job_vld,
   output job_type        job
);

   logic [EXT_BITS-1:0] left_ff, left_in, right_ff, right_in;
   logic [CNT_BITS-1:0] seen_ff, seen_in, emit_ff, emit_in;
   logic                q_vld_ff, q_vld_in;
   job_type             q_ff, q_in;

   logic                accept, wok, long_enough;
   logic [CNT_BITS-1:0] cnt;
   logic [EXT_BITS-1:0] maxext;
   logic [CNT_BITS+1:0] c34, e34, avail, rem;
   logic [NUM_BITS-1:0] nl_num;
   logic [EXT_BITS:0]   span;

   assign req_bus.ready = !q_vld_ff && back_sts.idle;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && req_bus.ready;

   assign span   = {1'b0, left_ff} + {1'b0, right_ff} + (EXT_BITS+1)'(1);
   assign wok    = (span <= (EXT_BITS+1)'(MAX_TAPS)) && (left_ff <= EXT_BITS'(EXT_LIMIT))
                   && (right_ff <= EXT_BITS'(EXT_LIMIT));
   assign maxext = (left_ff > right_ff) ? left_ff : right_ff;
   assign cnt    = seen_ff + CNT_BITS'(1);
   assign long_enough = cnt > {{(CNT_BITS-EXT_BITS){1'b0}}, maxext};
   assign c34    = {2'b00, cnt};
   assign e34    = {2'b00, emit_ff};
   assign avail  = c34 - {{(CNT_BITS+2-EXT_BITS){1'b0}}, right_ff} - e34;
   assign rem    = c34 - e34;
   assign nl_num = (avail > (CNT_BITS+2)'(MAX_RESULTS)) ? NUM_BITS'(MAX_RESULTS)
                                                        : avail[NUM_BITS-1:0];

   always_comb begin
      wr.tap_we   = accept && (req_bus.mode == MODE_TAP);
      wr.tap_addr = req_bus.tap_index;
      wr.tap_data = req_bus.coefficient;
      wr.ring_we  = accept && (req_bus.mode == MODE_SAMPLE);
      wr.head_we  = wr.ring_we && (seen_ff < CNT_BITS'(MAX_TAPS));
      wr.smp_addr = seen_ff[IDX_BITS-1:0];
      wr.smp_data = req_bus.sample;
   end

   assign ext.left  = left_ff;
   assign ext.right = right_ff;
   assign job_vld   = q_vld_ff;
   assign job       = q_ff;

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      seen_in  = seen_ff;
      emit_in  = emit_ff;
      q_vld_in = q_vld_ff && !back_sts.pop;
      q_in     = q_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_LEFT:  left_in  = csr_bus.data;
            REG_RIGHT: right_in = csr_bus.data;
            default:   left_in  = left_ff;
         endcase
      end
      if (wr.ring_we) begin
         q_in.count = cnt;
         q_in.first = emit_ff;
         if (req_bus.last) begin
            seen_in     = '0;
            emit_in     = '0;
            q_in.at_end = 1'b1;
            q_in.err    = !wok || !long_enough || (emit_ff > cnt)
                          || (rem > (CNT_BITS+2)'(MAX_RESULTS));
            q_in.num    = rem[NUM_BITS-1:0];
            q_vld_in    = q_in.err || (rem != '0);
         end else begin
            seen_in     = cnt;
            q_in.at_end = 1'b0;
            q_in.err    = 1'b0;
            q_in.num    = nl_num;
            q_vld_in    = wok && long_enough && !avail[CNT_BITS+1] && (avail != '0);
            if (q_vld_in) begin
               emit_in = emit_ff + {{(CNT_BITS-NUM_BITS){1'b0}}, nl_num};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= EXT_BITS'(2);
         right_ff <= EXT_BITS'(2);
         seen_ff  <= '0;
         emit_ff  <= '0;
         q_vld_ff <= 1'b0;
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
         seen_ff  <= seen_in;
         emit_ff  <= emit_in;
         q_vld_ff <= q_vld_in;
      end
      q_ff <= q_in;
   end

endmodule

FILE: hdl/sgs_back.sv
module sgs_back
   import sgs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  wr_type        wr,
   input  ext_type       ext,
   input  logic          job_vld,
   input  job_type       job,
   output back_sts_type  back_sts,
   sgs_rsp_if.source     rsp_bus
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_DRAIN = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   localparam int IB = CNT_BITS + 3;

   state_type state_ff, state_in;

   logic signed [COEF_BITS-1:0] tap_mem  [MAX_TAPS];
   logic signed [SMP_BITS-1:0]  head_mem [MAX_TAPS];
   logic signed [SMP_BITS-1:0]  ring_mem [MAX_TAPS];

   logic signed [COEF_BITS-1:0] tap_rd_ff;
   logic signed [SMP_BITS-1:0]  head_rd_ff, ring_rd_ff;
   logic                        sel_head_ff, rd_vld_ff, rd_vld_in;
   logic signed [COEF_BITS+SMP_BITS-1:0] prod_ff;
   logic                        mul_vld_ff;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;

   logic                        err_ff, err_in, at_end_ff, at_end_in;
   logic [CNT_BITS-1:0]         i_ff, i_in, count_ff, count_in;
   logic [NUM_BITS-1:0]         num_ff, num_in;
   logic [IDX_BITS-1:0]         k_ff, k_in;

   logic                        rsp_vld_ff, rsp_vld_in;
   logic signed [SMP_BITS-1:0]  smooth_ff, smooth_in;
   logic                        last_ff, last_in, error_ff, error_in;

   logic signed [IB-1:0]        idx, cnt_s;
   logic                        issue, out_free;
   logic [EXT_BITS:0]           points_m1;
   logic signed [SMP_BITS-1:0]  smp;
   logic signed [ACC_BITS-1:0]  rnd;
   logic signed [ACC_BITS-FRAC_BITS-1:0] q;

   assign issue     = (state_ff == S_ISSUE);
   assign points_m1 = {1'b0, ext.left} + {1'b0, ext.right};
   assign out_free  = !rsp_vld_ff || rsp_bus.ready;
   assign back_sts.idle = (state_ff == S_IDLE);
   assign back_sts.pop  = (state_ff == S_IDLE) && job_vld;

   always_comb begin
      cnt_s = $signed({3'b000, count_ff});
      idx   = $signed({3'b000, i_ff}) - $signed({{(IB-EXT_BITS){1'b0}}, ext.left})
              + $signed({{(IB-IDX_BITS){1'b0}}, k_ff});
      if (idx < 0) begin
         idx = -idx;
      end
      if (at_end_ff && (idx >= cnt_s)) begin
         idx = (cnt_s <<< 1) - IB'(2) - idx;
      end
      if (idx >= cnt_s) begin
         idx = cnt_s - IB'(1);
      end
      if (idx < 0) begin
         idx = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.tap_we) begin
         tap_mem[wr.tap_addr] <= wr.tap_data;
      end
      if (wr.head_we) begin
         head_mem[wr.smp_addr] <= wr.smp_data;
      end
      if (wr.ring_we) begin
         ring_mem[wr.smp_addr] <= wr.smp_data;
      end
      tap_rd_ff   <= tap_mem[k_ff];
      head_rd_ff  <= head_mem[idx[IDX_BITS-1:0]];
      ring_rd_ff  <= ring_mem[idx[IDX_BITS-1:0]];
      sel_head_ff <= (idx[IB-1:IDX_BITS] == '0);
   end

   assign smp = sel_head_ff ? head_rd_ff : ring_rd_ff;

   always_ff @(posedge clock) begin
      prod_ff <= tap_rd_ff * smp;
   end

   always_comb begin
      rnd = acc_ff + ACC_BITS'(1 << (FRAC_BITS - 1));
      q   = rnd[ACC_BITS-1:FRAC_BITS];
   end

   always_comb begin
      state_in   = state_ff;
      err_in     = err_ff;
      at_end_in  = at_end_ff;
      i_in       = i_ff;
      count_in   = count_ff;
      num_in     = num_ff;
      k_in       = k_ff;
      rd_vld_in  = issue;
      acc_in     = mul_vld_ff ? acc_ff + ACC_BITS'(prod_ff) : acc_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_bus.ready;
      smooth_in  = smooth_ff;
      last_in    = last_ff;
      error_in   = error_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (job_vld) begin
               err_in    = job.err;
               at_end_in = job.at_end;
               i_in      = job.first;
               count_in  = job.count;
               num_in    = job.num;
               k_in      = '0;
               acc_in    = '0;
               state_in  = job.err ? S_EMIT : S_ISSUE;
            end
         end
         S_ISSUE: begin
            k_in = k_ff + IDX_BITS'(1);
            if ({1'b0, k_ff} == points_m1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               error_in   = err_ff;
               if (err_ff) begin
                  smooth_in = '0;
                  last_in   = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  if (q > (ACC_BITS-FRAC_BITS)'(32767)) begin
                     smooth_in = 16'sh7fff;
                  end else if (q < -(ACC_BITS-FRAC_BITS)'(32768)) begin
                     smooth_in = 16'sh8000;
                  end else begin
                     smooth_in = q[SMP_BITS-1:0];
                  end
                  last_in = at_end_ff && (num_ff == NUM_BITS'(1));
                  if (num_ff == NUM_BITS'(1)) begin
                     state_in = S_IDLE;
                  end else begin
                     num_in   = num_ff - NUM_BITS'(1);
                     i_in     = i_ff + CNT_BITS'(1);
                     k_in     = '0;
                     acc_in   = '0;
                     state_in = S_ISSUE;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= rd_vld_ff;
         rsp_vld_ff <= rsp_vld_in;
      end
      acc_ff    <= acc_in;
      err_ff    <= err_in;
      at_end_ff <= at_end_in;
      i_ff      <= i_in;
      count_ff  <= count_in;
      num_ff    <= num_in;
      k_ff      <= k_in;
      smooth_ff <= smooth_in;
      last_ff   <= last_in;
      error_ff  <= error_in;
   end

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.smoothed    = smooth_ff;
   assign rsp_bus.last_result = last_ff;
   assign rsp_bus.error       = error_ff;

endmodule

FILE: hdl/sgs_check.sv
module sgs_check
   import sgs_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       csr_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SMP_BITS-1:0] rsp_smoothed,
   input logic                       rsp_last_result,
   input logic                       rsp_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_err_form: assert property (@(posedge clock)
      rsp_valid && rsp_error |-> rsp_last_result && (rsp_smoothed == '0))
      else $error("error item malformed");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr port stalled");

endmodule

bind savitzky_golay_smoother_top sgs_check u_sgs_check (
   .clock           (clock),
   .reset           (reset),
   .csr_ready       (csr_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_smoothed    (rsp_bus.smoothed),
   .rsp_last_result (rsp_bus.last_result),
   .rsp_error       (rsp_bus.error)
);
